@@ hw/rtl/jata_pkg.sv @@
// ----------------------------------------------------------------------------
// Joystick ADC trimmed average - shared package
// Widths, constants and the queue word type used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package jata_pkg;

  localparam int ChW     = 2;
  localparam int NumCh   = 3;
  localparam int MvW     = 12;
  localparam int ValW    = 14;
  localparam int SumW    = 18;
  localparam int CntW    = 4;
  localparam int ConvW   = 13;
  localparam int AxisW   = 12;

  localparam logic [ChW-1:0] ChAxisX  = 2'd0;
  localparam logic [ChW-1:0] ChAxisY  = 2'd1;
  localparam logic [ChW-1:0] ChSupply = 2'd2;
  localparam logic [ChW-1:0] ChNone   = 2'd3;

  // floor(x/3) = (x * Recip3) >> Recip3Shift for x < 2**17
  localparam logic [16:0] Recip3      = 17'd43691;
  localparam int          Recip3Shift = 17;
  // floor(u/10) = (u * Recip10) >> Recip10Shift for u < 2**14
  localparam logic [12:0] Recip10      = 13'd6554;
  localparam int          Recip10Shift = 16;

  localparam logic [ConvW-1:0] ClampLo    = 13'd500;
  localparam logic [ConvW-1:0] ClampHi    = 13'd4500;
  localparam logic signed [ValW-1:0] AxisOffset = 14'sd200;

  localparam int FifoDepth = 4;

  typedef struct packed {
    logic [ChW-1:0]         ch;
    logic signed [ValW-1:0] value;
  } sample_t;

endpackage

`default_nettype wire

@@ hw/rtl/jata_if.sv @@
// ----------------------------------------------------------------------------
// Joystick ADC trimmed average - stream interfaces
// Valid/ready channels for the sample input and the average output.
// ----------------------------------------------------------------------------
`default_nettype none

interface jata_in_if;
  logic                         valid;
  logic                         ready;
  logic [jata_pkg::ChW-1:0]     channel;
  logic [jata_pkg::MvW-1:0]     sample_mv;

  modport source (output valid, output channel, output sample_mv, input ready);
  modport sink   (input valid, input channel, input sample_mv, output ready);
endinterface

interface jata_out_if;
  logic                             valid;
  logic                             ready;
  logic [jata_pkg::ChW-1:0]         channel_out;
  logic signed [jata_pkg::ValW-1:0] average;
  logic                             changed;

  modport source (output valid, output channel_out, output average, output changed,
                  input ready);
  modport sink   (input valid, input channel_out, input average, input changed,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/joystick_adc_trimmed_average.sv @@
// ----------------------------------------------------------------------------
// Joystick ADC trimmed average - top level
// Per-channel trimmed-mean filter for joystick axes and supply voltage.
// ----------------------------------------------------------------------------
// Takes one sample word per cycle while ready is high. The front converts it
// over two stages (one constant multiply each), the first registered and the
// second writing a four-entry queue; the back updates that channel's sum,
// min, max and count as it pops a sample, and a completed window is held in
// the reciprocal divider stage register before the result word is registered.
// Channel code three is dropped. A stalled output holds the back end, and the
// queue plus the front stage absorb up to five samples before the input
// deasserts ready.
`default_nettype none

module joystick_adc_trimmed_average #(
  parameter int WINDOW = 10
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jata_in_if.sink    in_i,
  jata_out_if.source out_o
);

  logic              push, full, head_valid, pop;
  jata_pkg::sample_t push_data, head;

  jata_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  jata_fifo #(
    .DEPTH (jata_pkg::FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  jata_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) !full |-> in_i.ready)
    else $error("input stalled with queue space free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   head_valid |-> (head.ch != jata_pkg::ChNone))
    else $error("unused channel code reached the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_o.valid |-> (out_o.channel_out != jata_pkg::ChNone))
    else $error("result word carries unused channel code");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/jata_fifo.sv @@
// ----------------------------------------------------------------------------
// Joystick ADC trimmed average - sample queue
// Small register queue between the conversion front and the accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module jata_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire jata_pkg::sample_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output jata_pkg::sample_t      head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  jata_pkg::sample_t mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/jata_front.sv @@
// ----------------------------------------------------------------------------
// Joystick ADC trimmed average - conversion front
// Accept samples, drop the unused channel code, scale to degrees or doubled
// millivolts in two stages and push the result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jata_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  jata_in_if.sink            in_i,
  output logic               push_o,
  output jata_pkg::sample_t  push_data_o,
  input  wire logic          full_i
);

  localparam int ConvW = jata_pkg::ConvW;
  localparam int AxisW = jata_pkg::AxisW;
  localparam int ValW  = jata_pkg::ValW;

  logic                         s1_valid_q;
  logic [jata_pkg::ChW-1:0]     s1_ch_q;
  logic [ConvW-1:0]             s1_conv_q;
  logic [ConvW-1:0]             conv_d;
  logic                         s1_adv, keep;
  logic [14:0]                  mv5;
  logic [31:0]                  prod3;
  logic [ConvW-1:0]             clamped;
  logic [AxisW-1:0]             span;
  logic [24:0]                  prod10;
  logic signed [ValW-1:0]       axis_val;

  assign s1_adv     = !s1_valid_q || !full_i;
  assign in_i.ready = s1_adv;
  assign keep       = in_i.valid && s1_adv && (in_i.channel != jata_pkg::ChNone);

  // mv * 10 / 6 == mv * 5 / 3
  assign mv5   = {3'b000, in_i.sample_mv} + {1'b0, in_i.sample_mv, 2'b00};
  assign prod3 = 32'(mv5) * 32'(jata_pkg::Recip3);

  always_comb begin
    if (in_i.channel == jata_pkg::ChSupply) begin
      conv_d = {in_i.sample_mv, 1'b0};
    end else begin
      conv_d = prod3[jata_pkg::Recip3Shift +: ConvW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      s1_ch_q   <= in_i.channel;
      s1_conv_q <= conv_d;
    end
  end

  always_comb begin
    if (s1_conv_q < jata_pkg::ClampLo) begin
      clamped = jata_pkg::ClampLo;
    end else if (s1_conv_q > jata_pkg::ClampHi) begin
      clamped = jata_pkg::ClampHi;
    end else begin
      clamped = s1_conv_q;
    end
  end

  assign span     = AxisW'(clamped - jata_pkg::ClampLo);
  assign prod10   = 25'(span) * 25'(jata_pkg::Recip10);
  assign axis_val = $signed(ValW'(prod10[jata_pkg::Recip10Shift +: 9])) - jata_pkg::AxisOffset;

  assign push_o         = s1_valid_q && !full_i;
  assign push_data_o.ch = s1_ch_q;
  assign push_data_o.value = (s1_ch_q == jata_pkg::ChSupply) ?
                             $signed(ValW'(s1_conv_q)) : axis_val;

endmodule

`default_nettype wire

@@ hw/rtl/jata_back.sv @@
// ----------------------------------------------------------------------------
// Joystick ADC trimmed average - accumulator back end
// Update per-channel sum, min, max and count; on a full window divide the
// trimmed sum by a reciprocal multiply and register the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module jata_back #(
  parameter int WINDOW = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire jata_pkg::sample_t head_i,
  output logic                   pop_o,
  jata_out_if.source             out_o
);

  localparam int ValW      = jata_pkg::ValW;
  localparam int SumW      = jata_pkg::SumW;
  localparam int CntW      = jata_pkg::CntW;
  localparam int ChW       = jata_pkg::ChW;
  localparam int NumCh     = jata_pkg::NumCh;
  localparam int Div       = WINDOW - 2;
  localparam int DivShift  = 22;
  localparam int RecipW    = DivShift + 1;
  localparam int Recip     = (2 ** DivShift + Div - 1) / Div;
  localparam int ProdW     = SumW + RecipW;

  logic [CntW-1:0]        cnt_q [NumCh];
  logic signed [SumW-1:0] sum_q [NumCh];
  logic signed [ValW-1:0] min_q [NumCh];
  logic signed [ValW-1:0] max_q [NumCh];
  logic signed [ValW-1:0] last_q [NumCh];

  logic [ChW-1:0]         ch;
  logic signed [ValW-1:0] v;
  logic                   first, last_win;
  logic signed [SumW-1:0] sum_d;
  logic signed [ValW-1:0] min_d, max_d;
  logic signed [SumW-1:0] num;
  logic [SumW-1:0]        mag_d;

  logic                   b2_valid_q;
  logic [ChW-1:0]         b2_ch_q;
  logic                   b2_neg_q;
  logic [SumW-1:0]        b2_mag_q;
  logic [ProdW-1:0]       prod;
  logic [ValW-1:0]        quo;
  logic signed [ValW-1:0] avg;

  logic                   out_valid_q;
  logic [ChW-1:0]         out_ch_q;
  logic signed [ValW-1:0] out_avg_q;
  logic                   out_chg_q;
  logic                   out_free, b2_free;

  assign ch       = head_i.ch;
  assign v        = head_i.value;
  assign first    = (cnt_q[ch] == '0);
  assign last_win = (cnt_q[ch] == CntW'(WINDOW - 1));

  assign out_free = !out_valid_q || out_o.ready;
  assign b2_free  = !b2_valid_q || out_free;
  assign pop_o    = head_valid_i && (!last_win || b2_free);

  always_comb begin
    if (first) begin
      sum_d = SumW'(v);
      min_d = v;
      max_d = v;
    end else begin
      sum_d = sum_q[ch] + SumW'(v);
      min_d = (v < min_q[ch]) ? v : min_q[ch];
      max_d = (v > max_q[ch]) ? v : max_q[ch];
    end
    num   = sum_d - SumW'(min_d) - SumW'(max_d);
    mag_d = num[SumW-1] ? SumW'(-num) : SumW'(num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (pop_o) begin
      cnt_q[ch] <= last_win ? '0 : cnt_q[ch] + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sum_q[ch] <= sum_d;
      min_q[ch] <= min_d;
      max_q[ch] <= max_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else if (b2_free) begin
      b2_valid_q <= pop_o && last_win;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_free && pop_o && last_win) begin
      b2_ch_q  <= ch;
      b2_neg_q <= num[SumW-1];
      b2_mag_q <= mag_d;
    end
  end

  assign prod = ProdW'(b2_mag_q) * ProdW'(RecipW'(Recip));
  assign quo  = prod[DivShift +: ValW];
  assign avg  = b2_neg_q ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCh; i++) begin
        last_q[i] <= '0;
      end
    end else if (out_free) begin
      out_valid_q <= b2_valid_q;
      if (b2_valid_q) begin
        last_q[b2_ch_q] <= avg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && b2_valid_q) begin
      out_ch_q  <= b2_ch_q;
      out_avg_q <= avg;
      out_chg_q <= (avg != last_q[b2_ch_q]);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.average     = out_avg_q;
  assign out_o.changed     = out_chg_q;

endmodule

`default_nettype wire
